@@ hw/rtl/tcpop_pkg.sv @@
// Shared types and constants for the TCP option parser.
package tcpop_pkg;

    // Default limit on option area length
    localparam int MAX_AREA_BYTES_DEF = 40;

    // Option kind codes
    localparam logic [7:0] KIND_EOL       = 8'd0;
    localparam logic [7:0] KIND_NOP       = 8'd1;
    localparam logic [7:0] KIND_MSS       = 8'd2;
    localparam logic [7:0] KIND_WSCALE    = 8'd3;
    localparam logic [7:0] KIND_SACK_PERM = 8'd4;
    localparam logic [7:0] KIND_SACK      = 8'd5;
    localparam logic [7:0] KIND_TS        = 8'd8;

    // Expected option lengths, kind and length bytes included
    localparam logic [7:0] LEN_MIN        = 8'd2;
    localparam logic [7:0] LEN_MSS        = 8'd4;
    localparam logic [7:0] LEN_WSCALE     = 8'd3;
    localparam logic [7:0] LEN_SACK_PERM  = 8'd2;
    localparam logic [7:0] LEN_TS         = 8'd10;

    // Largest window shift allowed
    localparam logic [7:0] SCALE_MAX      = 8'd14;

    // Register index decoded from paddr[2]
    localparam logic CFG_IDX_SACK_PERM_EN = 1'b0;

    // One input request
    typedef struct packed {
        logic [7:0] option_byte;
        logic       first_byte;
        logic [5:0] area_length;
        logic       syn_flag;
        logic       past_syn;
    } tcpop_item_t;

    // One result request
    typedef struct packed {
        logic        mss_valid;
        logic [15:0] mss_value;
        logic        scale_valid;
        logic [3:0]  scale_shift;
        logic        ts_seen;
        logic [31:0] ts_value;
        logic [31:0] ts_echo;
        logic        ts_enable;
        logic        sack_permit;
        logic        sack_block_seen;
    } tcpop_result_t;

endpackage

@@ hw/rtl/tcp_option_parser_core.sv @@
// Top level of the TCP option parser.
//
// Usage: option bytes of one TCP segment enter on the input channel
// (in_valid / in_stall), one byte per request, with first_byte set on the
// first byte of the area. Each byte carries the area length and the SYN
// state of the segment. On the last byte of the area one result request
// with MSS, window scale, timestamp and SACK flags leaves on the output
// channel (out_valid / out_stall); other bytes give no result.
// The last byte of an area passes the input register, then the result
// register, whose load raises out_valid. Throughput: one byte per cycle
// while in_stall is low, as the per-byte parse state updates on every
// byte that it takes. While the receiver stalls, the waiting result holds;
// bytes that give no result keep flowing, and the input stalls only when a
// byte that closes an area meets a full result register.
// Reset: both stages empty, parse state at the start of a segment,
// SACK permitted enable set. The enable sits at APB byte address 0.
module tcp_option_parser_core #(
    parameter int MAX_AREA_BYTES = tcpop_pkg::MAX_AREA_BYTES_DEF
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    output logic        in_stall,
    input  logic [7:0]  option_byte,
    input  logic        first_byte,
    input  logic [5:0]  area_length,
    input  logic        syn_flag,
    input  logic        past_syn,
    output logic        out_valid,
    input  logic        out_stall,
    output logic        mss_valid,
    output logic [15:0] mss_value,
    output logic        scale_valid,
    output logic [3:0]  scale_shift,
    output logic        ts_seen,
    output logic [31:0] ts_value,
    output logic [31:0] ts_echo,
    output logic        ts_enable,
    output logic        sack_permit,
    output logic        sack_block_seen,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [2:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready
);
    import tcpop_pkg::*;

    tcpop_item_t   in_item;
    tcpop_item_t   s1_item;
    logic          s1_valid;
    logic          s1_fire;
    logic          emit;
    logic          out_free;
    logic          sack_perm_en;
    tcpop_result_t parse_result;
    tcpop_result_t out_result;

    assign in_item.option_byte = option_byte;
    assign in_item.first_byte  = first_byte;
    assign in_item.area_length = area_length;
    assign in_item.syn_flag    = syn_flag;
    assign in_item.past_syn    = past_syn;

    tcpop_cfg u_cfg (
        .clk          (clk),
        .rst_n        (rst_n),
        .psel         (psel),
        .penable      (penable),
        .pwrite       (pwrite),
        .paddr        (paddr),
        .pwdata       (pwdata),
        .prdata       (prdata),
        .pready       (pready),
        .sack_perm_en (sack_perm_en)
    );

    tcpop_in_stage u_in_stage (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .in_stall (in_stall),
        .in_item  (in_item),
        .advance  (s1_fire),
        .s1_valid (s1_valid),
        .s1_item  (s1_item)
    );

    // Take the byte unless its result finds the result register full
    assign s1_fire = s1_valid && (!emit || out_free);

    tcpop_parse #(
        .MAX_AREA_BYTES (MAX_AREA_BYTES)
    ) u_parse (
        .clk          (clk),
        .rst_n        (rst_n),
        .item         (s1_item),
        .take         (s1_fire),
        .sack_perm_en (sack_perm_en),
        .emit         (emit),
        .result       (parse_result)
    );

    tcpop_out_stage u_out_stage (
        .clk         (clk),
        .rst_n       (rst_n),
        .load        (s1_fire && emit),
        .load_result (parse_result),
        .free        (out_free),
        .out_valid   (out_valid),
        .out_stall   (out_stall),
        .out_result  (out_result)
    );

    assign mss_valid       = out_result.mss_valid;
    assign mss_value       = out_result.mss_value;
    assign scale_valid     = out_result.scale_valid;
    assign scale_shift     = out_result.scale_shift;
    assign ts_seen         = out_result.ts_seen;
    assign ts_value        = out_result.ts_value;
    assign ts_echo         = out_result.ts_echo;
    assign ts_enable       = out_result.ts_enable;
    assign sack_permit     = out_result.sack_permit;
    assign sack_block_seen = out_result.sack_block_seen;

endmodule

@@ hw/rtl/tcpop_cfg.sv @@
// APB configuration register for the TCP option parser.
module tcpop_cfg (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [2:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready,
    output logic        sack_perm_en
);
    import tcpop_pkg::*;

    logic sack_perm_en_reg;
    logic sack_perm_en_next;
    logic wr_sack;

    assign pready = 1'b1;

    // Decode the write access
    assign wr_sack = psel && penable && pwrite && (paddr[2] == CFG_IDX_SACK_PERM_EN);

    always_comb
    begin
        sack_perm_en_next = sack_perm_en_reg;
        if (wr_sack)
        begin
            sack_perm_en_next = pwdata[0];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            sack_perm_en_reg <= 1'b1;
        end
        else
        begin
            sack_perm_en_reg <= sack_perm_en_next;
        end
    end

    // Return the register value, zero elsewhere
    assign prdata = (paddr[2] == CFG_IDX_SACK_PERM_EN) ? {31'd0, sack_perm_en_reg} : 32'd0;

    assign sack_perm_en = sack_perm_en_reg;

endmodule

@@ hw/rtl/tcpop_in_stage.sv @@
// Input register stage of the TCP option parser.
module tcpop_in_stage (
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   in_valid,
    output logic                   in_stall,
    input  tcpop_pkg::tcpop_item_t in_item,
    input  logic                   advance,
    output logic                   s1_valid,
    output tcpop_pkg::tcpop_item_t s1_item
);
    import tcpop_pkg::*;

    logic        valid_reg;
    logic        valid_next;
    tcpop_item_t item_reg;
    logic        load;

    // Hold the request while the parse stage cannot take it
    assign in_stall = valid_reg && !advance;
    assign load     = in_valid && !in_stall;

    always_comb
    begin
        valid_next = valid_reg;
        if (load)
        begin
            valid_next = 1'b1;
        end
        else if (advance)
        begin
            valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (load)
        begin
            item_reg <= in_item;
        end
    end

    assign s1_valid = valid_reg;
    assign s1_item  = item_reg;

endmodule

@@ hw/rtl/tcpop_parse.sv @@
// Per-byte option parse state and its combinational update.
module tcpop_parse #(
    parameter int MAX_AREA_BYTES = tcpop_pkg::MAX_AREA_BYTES_DEF
) (
    input  logic                     clk,
    input  logic                     rst_n,
    input  tcpop_pkg::tcpop_item_t   item,
    input  logic                     take,
    input  logic                     sack_perm_en,
    output logic                     emit,
    output tcpop_pkg::tcpop_result_t result
);
    import tcpop_pkg::*;

    localparam logic [5:0] AREA_MAX = 6'(MAX_AREA_BYTES);

    typedef enum logic [1:0] {
        PH_KIND,
        PH_LEN,
        PH_BODY,
        PH_STOP
    } phase_t;

    typedef struct packed {
        phase_t      phase;
        logic [5:0]  position;
        logic [7:0]  kind;
        logic [7:0]  length;
        logic [5:0]  offset;
        logic [63:0] shift;
        logic        mss_valid;
        logic [15:0] mss_value;
        logic        scale_valid;
        logic [3:0]  scale_shift;
        logic        ts_seen;
        logic        ts_enable;
        logic [63:0] ts_word;
        logic        sack_permit;
        logic        sack_block_seen;
    } parse_state_t;

    localparam parse_state_t STATE_CLEAR = '{
        phase: PH_KIND, position: 6'd0, kind: 8'd0, length: 8'd0, offset: 6'd0,
        shift: 64'd0, mss_valid: 1'b0, mss_value: 16'd0, scale_valid: 1'b0,
        scale_shift: 4'd0, ts_seen: 1'b0, ts_enable: 1'b0, ts_word: 64'd0,
        sack_permit: 1'b0, sack_block_seen: 1'b0
    };

    parse_state_t state_reg;
    parse_state_t state_next;
    parse_state_t cur;
    logic [5:0]   area;
    logic [6:0]   len_limit;
    logic         initial_syn;
    logic         finish;
    logic         emit_int;

    always_comb
    begin
        // Saturate the area length and start afresh on a segment's first byte
        area        = (item.area_length > AREA_MAX) ? AREA_MAX : item.area_length;
        initial_syn = item.syn_flag && !item.past_syn;
        cur         = item.first_byte ? STATE_CLEAR : state_reg;
        state_next  = cur;
        finish      = 1'b0;
        emit_int    = 1'b0;
        len_limit   = {1'b0, area} - {1'b0, cur.position} + 7'd1;

        if (cur.position < area)
        begin
            // Advance the option walk by one byte
            case (cur.phase)
                PH_KIND:
                begin
                    if (item.option_byte == KIND_EOL)
                    begin
                        state_next.phase = PH_STOP;
                    end
                    else if (item.option_byte == KIND_NOP)
                    begin
                        state_next.phase = PH_KIND;
                    end
                    else if ((area - cur.position) < 6'd2)
                    begin
                        state_next.phase = PH_STOP;
                    end
                    else
                    begin
                        state_next.kind  = item.option_byte;
                        state_next.phase = PH_LEN;
                    end
                end
                PH_LEN:
                begin
                    if ((item.option_byte < LEN_MIN) || (item.option_byte > {1'b0, len_limit}))
                    begin
                        state_next.phase = PH_STOP;
                    end
                    else
                    begin
                        state_next.length = item.option_byte;
                        state_next.offset = 6'd0;
                        state_next.shift  = 64'd0;
                        if (item.option_byte == LEN_MIN)
                        begin
                            finish           = 1'b1;
                            state_next.phase = PH_KIND;
                        end
                        else
                        begin
                            state_next.phase = PH_BODY;
                        end
                    end
                end
                PH_BODY:
                begin
                    state_next.shift  = {cur.shift[55:0], item.option_byte};
                    state_next.offset = cur.offset + 6'd1;
                    if ((8'(state_next.offset) + LEN_MIN) >= cur.length)
                    begin
                        finish           = 1'b1;
                        state_next.phase = PH_KIND;
                    end
                end
                default:
                begin
                    state_next.phase = PH_STOP;
                end
            endcase

            state_next.position = cur.position + 6'd1;
            emit_int            = (state_next.position == area);
        end

        // Capture the completed option
        if (finish)
        begin
            if ((state_next.kind == KIND_MSS) && (state_next.length == LEN_MSS))
            begin
                if (initial_syn)
                begin
                    state_next.mss_valid = 1'b1;
                    state_next.mss_value = state_next.shift[15:0];
                end
            end
            else if ((state_next.kind == KIND_WSCALE) && (state_next.length == LEN_WSCALE))
            begin
                if (initial_syn)
                begin
                    state_next.scale_valid = 1'b1;
                    state_next.scale_shift = (state_next.shift[7:0] > SCALE_MAX) ?
                                             SCALE_MAX[3:0] : state_next.shift[3:0];
                end
            end
            else if ((state_next.kind == KIND_TS) && (state_next.length == LEN_TS))
            begin
                state_next.ts_word = state_next.shift;
                state_next.ts_seen = 1'b1;
                if (initial_syn)
                begin
                    state_next.ts_enable = 1'b1;
                end
            end
            else if ((state_next.kind == KIND_SACK_PERM) &&
                     (state_next.length == LEN_SACK_PERM))
            begin
                if (sack_perm_en && initial_syn)
                begin
                    state_next.sack_permit = 1'b1;
                end
            end
            else if (state_next.kind == KIND_SACK)
            begin
                state_next.sack_block_seen = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= STATE_CLEAR;
        end
        else if (take)
        begin
            state_reg <= state_next;
        end
    end

    // Result as it stands after this byte
    assign emit                   = emit_int;
    assign result.mss_valid       = state_next.mss_valid;
    assign result.mss_value       = state_next.mss_value;
    assign result.scale_valid     = state_next.scale_valid;
    assign result.scale_shift     = state_next.scale_shift;
    assign result.ts_seen         = state_next.ts_seen;
    assign result.ts_value        = state_next.ts_word[63:32];
    assign result.ts_echo         = state_next.ts_word[31:0];
    assign result.ts_enable       = state_next.ts_enable;
    assign result.sack_permit     = state_next.sack_permit;
    assign result.sack_block_seen = state_next.sack_block_seen;

endmodule

@@ hw/rtl/tcpop_out_stage.sv @@
// Result register stage of the TCP option parser.
module tcpop_out_stage (
    input  logic                     clk,
    input  logic                     rst_n,
    input  logic                     load,
    input  tcpop_pkg::tcpop_result_t load_result,
    output logic                     free,
    output logic                     out_valid,
    input  logic                     out_stall,
    output tcpop_pkg::tcpop_result_t out_result
);
    import tcpop_pkg::*;

    logic          valid_reg;
    logic          valid_next;
    tcpop_result_t result_reg;

    // Free when empty or the waiting request leaves this cycle
    assign free = !valid_reg || !out_stall;

    always_comb
    begin
        valid_next = valid_reg;
        if (load)
        begin
            valid_next = 1'b1;
        end
        else if (!out_stall)
        begin
            valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (load)
        begin
            result_reg <= load_result;
        end
    end

    assign out_valid  = valid_reg;
    assign out_result = result_reg;

endmodule

@@ dv/tcp_option_parser_core_test.sv @@
// Self-checking testbench for the TCP option parser core: segment stimulus and summary check.
`timescale 1ns / 1ps

module tcp_option_parser_core_test;
    import tcpop_pkg::*;

    typedef enum logic [1:0] {
        WALK_KIND,
        WALK_LEN,
        WALK_BODY,
        WALK_HALT
    } walk_t;

    // Tracks the parse of each option area and holds the summaries still to arrive
    class tcpop_tracker;
        bit                sack_perm_en;
        walk_t             walk;
        int                pos;
        int                kind;
        int                opt_len;
        int                body_cnt;
        logic [63:0]       body_bytes;
        bit                mss_ok;
        logic [15:0]       mss;
        bit                scale_ok;
        logic [3:0]        shift;
        bit                ts_ok;
        bit                ts_on;
        logic [63:0]       ts_word;
        bit                permit;
        bit                sack_seen;
        tcpop_result_t     pending_summaries[$];
        int                mismatches;
        int                summaries_seen;

        function new();
            sack_perm_en   = 1'b1;
            mismatches     = 0;
            summaries_seen = 0;
            clear_segment();
        endfunction

        function void clear_segment();
            walk       = WALK_KIND;
            pos        = 0;
            kind       = 0;
            opt_len    = 0;
            body_cnt   = 0;
            body_bytes = '0;
            mss_ok     = 1'b0;
            mss        = '0;
            scale_ok   = 1'b0;
            shift      = '0;
            ts_ok      = 1'b0;
            ts_on      = 1'b0;
            ts_word    = '0;
            permit     = 1'b0;
            sack_seen  = 1'b0;
        endfunction

        // Take the value of an option whose last byte has just been seen
        function void close_option(bit initial_syn);
            logic [7:0] s;
            s = body_bytes[7:0];
            if (kind == int'(KIND_MSS) && opt_len == int'(LEN_MSS))
            begin
                if (initial_syn)
                begin
                    mss_ok = 1'b1;
                    mss    = body_bytes[15:0];
                end
            end
            else if (kind == int'(KIND_WSCALE) && opt_len == int'(LEN_WSCALE))
            begin
                if (initial_syn)
                begin
                    if (s > SCALE_MAX)
                        s = SCALE_MAX;
                    scale_ok = 1'b1;
                    shift    = s[3:0];
                end
            end
            else if (kind == int'(KIND_TS) && opt_len == int'(LEN_TS))
            begin
                ts_word = body_bytes;
                ts_ok   = 1'b1;
                if (initial_syn)
                    ts_on = 1'b1;
            end
            else if (kind == int'(KIND_SACK_PERM) && opt_len == int'(LEN_SACK_PERM))
            begin
                if (sack_perm_en && initial_syn)
                    permit = 1'b1;
            end
            else if (kind == int'(KIND_SACK))
            begin
                sack_seen = 1'b1;
            end
        endfunction

        // Advance the parse by one accepted byte; returns 1 when the byte lay inside the area
        function bit take_byte(tcpop_item_t it);
            int            area;
            bit            initial_syn;
            logic [7:0]    b;
            tcpop_result_t r;
            b    = it.option_byte;
            area = int'(it.area_length);
            if (area > MAX_AREA_BYTES_DEF)
                area = MAX_AREA_BYTES_DEF;
            initial_syn = it.syn_flag && !it.past_syn;
            if (it.first_byte)
                clear_segment();
            if (pos >= area)
                return 1'b0;

            case (walk)
                WALK_KIND:
                begin
                    if (b == KIND_EOL)
                        walk = WALK_HALT;
                    else if (b == KIND_NOP)
                        walk = WALK_KIND;
                    else if (area - pos < 2)
                        walk = WALK_HALT;
                    else
                    begin
                        kind = int'(b);
                        walk = WALK_LEN;
                    end
                end
                WALK_LEN:
                begin
                    // kind byte sat one position earlier
                    if (b < LEN_MIN || int'(b) > area - (pos - 1))
                        walk = WALK_HALT;
                    else
                    begin
                        opt_len    = int'(b);
                        body_cnt   = 0;
                        body_bytes = '0;
                        if (b == LEN_MIN)
                        begin
                            close_option(initial_syn);
                            walk = WALK_KIND;
                        end
                        else
                            walk = WALK_BODY;
                    end
                end
                WALK_BODY:
                begin
                    body_bytes = {body_bytes[55:0], b};
                    body_cnt   = (body_cnt + 1) & 63;
                    if (body_cnt + 2 >= opt_len)
                    begin
                        close_option(initial_syn);
                        walk = WALK_KIND;
                    end
                end
                default: ;
            endcase

            pos++;
            if (pos == area)
            begin
                r.mss_valid       = mss_ok;
                r.mss_value       = mss;
                r.scale_valid     = scale_ok;
                r.scale_shift     = shift;
                r.ts_seen         = ts_ok;
                r.ts_value        = ts_word[63:32];
                r.ts_echo         = ts_word[31:0];
                r.ts_enable       = ts_on;
                r.sack_permit     = permit;
                r.sack_block_seen = sack_seen;
                pending_summaries.push_back(r);
            end
            return 1'b1;
        endfunction

        task report_mismatch(string msg);
            mismatches++;
            $display("[%0t] mismatch: %s", $realtime, msg);
        endtask

        task cmp(string name, logic [31:0] got, logic [31:0] want);
            if (got !== want)
                report_mismatch($sformatf("%s got 0x%0h want 0x%0h", name, got, want));
        endtask

        // Check one summary from the block against the oldest one predicted
        task match_summary(tcpop_result_t got);
            tcpop_result_t want;
            summaries_seen++;
            if (pending_summaries.size() == 0)
            begin
                report_mismatch("summary arrived with none predicted");
                return;
            end
            want = pending_summaries.pop_front();
            cmp("mss_valid", 32'(got.mss_valid), 32'(want.mss_valid));
            cmp("mss_value", 32'(got.mss_value), 32'(want.mss_value));
            cmp("scale_valid", 32'(got.scale_valid), 32'(want.scale_valid));
            cmp("scale_shift", 32'(got.scale_shift), 32'(want.scale_shift));
            cmp("ts_seen", 32'(got.ts_seen), 32'(want.ts_seen));
            cmp("ts_value", got.ts_value, want.ts_value);
            cmp("ts_echo", got.ts_echo, want.ts_echo);
            cmp("ts_enable", 32'(got.ts_enable), 32'(want.ts_enable));
            cmp("sack_permit", 32'(got.sack_permit), 32'(want.sack_permit));
            cmp("sack_block_seen", 32'(got.sack_block_seen), 32'(want.sack_block_seen));
        endtask
    endclass

    localparam int RUN_LIMIT       = 200000;
    localparam int SETTLE_CYCLES   = 8;
    localparam int HOLD_CYCLES     = 400;
    localparam int BYTES_PER_PHASE = 375;
    localparam logic [2:0] SACK_ADDR = {CFG_IDX_SACK_PERM_EN, 2'b00};

    logic        clk;
    logic        rst_n;
    logic        in_valid;
    logic        in_stall;
    logic [7:0]  option_byte;
    logic        first_byte;
    logic [5:0]  area_length;
    logic        syn_flag;
    logic        past_syn;
    logic        out_valid;
    logic        out_stall;
    logic        mss_valid;
    logic [15:0] mss_value;
    logic        scale_valid;
    logic [3:0]  scale_shift;
    logic        ts_seen;
    logic [31:0] ts_value;
    logic [31:0] ts_echo;
    logic        ts_enable;
    logic        sack_permit;
    logic        sack_block_seen;
    logic        psel;
    logic        penable;
    logic        pwrite;
    logic [2:0]  paddr;
    logic [31:0] pwdata;
    logic [31:0] prdata;
    logic        pready;

    tcpop_tracker tracker;
    logic [7:0]   seg_bytes[$];
    int           send_idle_pct = 0;
    int           recv_idle_pct = 0;
    bit           hold_request  = 1'b0;
    int           hold_left;
    int           cycle_count   = 0;
    int           used_bytes    = 0;
    int           segments      = 0;

    tcp_option_parser_core dut (
        .clk             (clk),
        .rst_n           (rst_n),
        .in_valid        (in_valid),
        .in_stall        (in_stall),
        .option_byte     (option_byte),
        .first_byte      (first_byte),
        .area_length     (area_length),
        .syn_flag        (syn_flag),
        .past_syn        (past_syn),
        .out_valid       (out_valid),
        .out_stall       (out_stall),
        .mss_valid       (mss_valid),
        .mss_value       (mss_value),
        .scale_valid     (scale_valid),
        .scale_shift     (scale_shift),
        .ts_seen         (ts_seen),
        .ts_value        (ts_value),
        .ts_echo         (ts_echo),
        .ts_enable       (ts_enable),
        .sack_permit     (sack_permit),
        .sack_block_seen (sack_block_seen),
        .psel            (psel),
        .penable         (penable),
        .pwrite          (pwrite),
        .paddr           (paddr),
        .pwdata          (pwdata),
        .prdata          (prdata),
        .pready          (pready)
    );

    // Free-running clock
    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    // Abandon the run if it hangs
    initial
    begin
        while (cycle_count < RUN_LIMIT)
        begin
            @(posedge clk);
            cycle_count++;
        end
        $display("FAILURE");
        $finish;
    end

    // Receiver stall: random, or a long hold-off when asked for
    initial
    begin
        hold_left = 0;
        out_stall = 1'b0;
        forever
        begin
            @(negedge clk);
            if (hold_left > 0)
            begin
                hold_left--;
                out_stall <= 1'b1;
            end
            else if (hold_request)
            begin
                hold_request = 1'b0;
                hold_left    = HOLD_CYCLES - 1;
                out_stall    <= 1'b1;
            end
            else
                out_stall <= ($urandom_range(99) < recv_idle_pct);
        end
    end

    // Check every summary request taken from the block
    always @(posedge clk)
    begin
        tcpop_result_t got;
        if (rst_n && out_valid && !out_stall)
        begin
            got.mss_valid       = mss_valid;
            got.mss_value       = mss_value;
            got.scale_valid     = scale_valid;
            got.scale_shift     = scale_shift;
            got.ts_seen         = ts_seen;
            got.ts_value        = ts_value;
            got.ts_echo         = ts_echo;
            got.ts_enable       = ts_enable;
            got.sack_permit     = sack_permit;
            got.sack_block_seen = sack_block_seen;
            tracker.match_summary(got);
        end
    end

    // Offer one byte request, idling at random first, and hold it until taken
    task automatic send_request(input tcpop_item_t it);
        while ($urandom_range(99) < send_idle_pct)
        begin
            @(negedge clk);
            in_valid <= 1'b0;
        end
        @(negedge clk);
        in_valid    <= 1'b1;
        option_byte <= it.option_byte;
        first_byte  <= it.first_byte;
        area_length <= it.area_length;
        syn_flag    <= it.syn_flag;
        past_syn    <= it.past_syn;
        do
            @(posedge clk);
        while (in_stall);
        if (tracker.take_byte(it))
            used_bytes++;
    endtask

    // Write the SACK permitted enable, then read it back
    task automatic write_sack_perm_en(input bit value);
        logic [31:0] data;
        data    = $urandom();
        data[0] = value;
        @(negedge clk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= SACK_ADDR;
        pwdata  <= data;
        @(negedge clk);
        penable <= 1'b1;
        do
            @(posedge clk);
        while (!pready);
        tracker.sack_perm_en = value;
        @(negedge clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        @(negedge clk);
        psel    <= 1'b1;
        pwrite  <= 1'b0;
        @(negedge clk);
        penable <= 1'b1;
        do
            @(posedge clk);
        while (!pready);
        if (prdata !== {31'b0, value})
            tracker.report_mismatch($sformatf("SACK permitted enable read 0x%0h", prdata));
        @(negedge clk);
        psel    <= 1'b0;
        penable <= 1'b0;
    endtask

    // Drop valid, drain all predicted summaries, then let the pipeline empty
    task automatic wait_quiet();
        @(negedge clk);
        in_valid <= 1'b0;
        while (tracker.pending_summaries.size() != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    function void push_random(int n);
        repeat (n) seg_bytes.push_back(8'($urandom_range(0, 255)));
    endfunction

    // Append one option within the bytes left, at times a malformed one; fall back to a filler
    function void add_option(int room);
        int         cap;
        int         n;
        logic [7:0] k;
        case ($urandom_range(0, 13))
            0, 1:
                if (room >= 4)
                begin
                    seg_bytes.push_back(KIND_MSS);
                    seg_bytes.push_back(LEN_MSS);
                    push_random(2);
                end
                else
                    seg_bytes.push_back(KIND_NOP);
            2, 3:
                if (room >= 3)
                begin
                    seg_bytes.push_back(KIND_WSCALE);
                    seg_bytes.push_back(LEN_WSCALE);
                    seg_bytes.push_back(8'($urandom_range(0, 1) ? $urandom_range(0, 15)
                                                                : $urandom_range(0, 255)));
                end
                else
                    seg_bytes.push_back(KIND_NOP);
            4, 5:
                if (room >= 10)
                begin
                    seg_bytes.push_back(KIND_TS);
                    seg_bytes.push_back(LEN_TS);
                    push_random(8);
                end
                else
                    seg_bytes.push_back(KIND_NOP);
            6:
                if (room >= 2)
                begin
                    seg_bytes.push_back(KIND_SACK_PERM);
                    seg_bytes.push_back(LEN_SACK_PERM);
                end
                else
                    seg_bytes.push_back(KIND_NOP);
            7:
                if (room >= 2)
                begin
                    cap = (room - 2) / 8;
                    if (cap > 4)
                        cap = 4;
                    n = int'($urandom_range(0, cap));
                    seg_bytes.push_back(KIND_SACK);
                    seg_bytes.push_back(8'(2 + 8 * n));
                    push_random(8 * n);
                end
                else
                    seg_bytes.push_back(KIND_NOP);
            8, 9:
                seg_bytes.push_back(KIND_NOP);
            10:
            begin
                // end of list, rest is junk
                seg_bytes.push_back(KIND_EOL);
                push_random(room - 1);
            end
            11:
                // known kind with an arbitrary length
                if (room >= 2)
                begin
                    case ($urandom_range(0, 3))
                        0: k = KIND_MSS;
                        1: k = KIND_WSCALE;
                        2: k = KIND_SACK_PERM;
                        default: k = KIND_TS;
                    endcase
                    n = int'($urandom_range(2, (room > 12) ? 12 : room));
                    seg_bytes.push_back(k);
                    seg_bytes.push_back(8'(n));
                    push_random(n - 2);
                end
                else
                    seg_bytes.push_back(KIND_NOP);
            12:
                // kind the block does not know
                if (room >= 2)
                begin
                    k = 8'($urandom_range(6, 255));
                    if (k == KIND_TS)
                        k = 8'd6;
                    n = int'($urandom_range(2, (room > 8) ? 8 : room));
                    seg_bytes.push_back(k);
                    seg_bytes.push_back(8'(n));
                    push_random(n - 2);
                end
                else
                    seg_bytes.push_back(KIND_NOP);
            default:
            begin
                // length under two or past the area end, or a kind in the last byte
                seg_bytes.push_back(8'($urandom_range(2, 255)));
                if (room >= 2)
                begin
                    seg_bytes.push_back(8'($urandom_range(0, 1) ? $urandom_range(0, 1)
                                                                : room + $urandom_range(1, 20)));
                    push_random(room - 2);
                end
            end
        endcase
    endfunction

    // Send the bytes held in seg_bytes as one clean area
    task automatic send_run(input int area, input bit syn, input bit past);
        tcpop_item_t it;
        for (int i = 0; i < seg_bytes.size(); i++)
        begin
            it.option_byte = seg_bytes[i];
            it.first_byte  = (i == 0);
            it.area_length = 6'(area);
            it.syn_flag    = syn;
            it.past_syn    = past;
            send_request(it);
        end
        segments++;
    endtask

    // Build and send one random segment, optionally disturbed
    task automatic send_segment(input bit noisy);
        tcpop_item_t it;
        int          fill_len;
        int          shown_area;
        int          noise;
        int          odd_idx;
        int          syn_mode;
        bit          syn;
        bit          past;
        noise    = noisy ? int'($urandom_range(1, 5)) : 0;
        fill_len = int'($urandom_range(1, 40));
        if (noise == 1)
            fill_len = 40;
        if (noise == 5)
            fill_len = int'($urandom_range(1, 4));

        seg_bytes.delete();
        if ($urandom_range(0, 9) == 0)
            push_random(fill_len);
        else
            while (seg_bytes.size() < fill_len)
                add_option(fill_len - seg_bytes.size());

        case (noise)
            1: shown_area = int'($urandom_range(41, 63));
            5: shown_area = 0;
            default: shown_area = fill_len;
        endcase
        odd_idx  = (noise == 3) ? int'($urandom_range(0, fill_len - 1)) : -1;
        syn_mode = int'($urandom_range(0, 3));
        syn      = (syn_mode != 3) ? 1'b1 : 1'($urandom_range(0, 1));
        past     = (syn_mode == 2) ? 1'b1 :
                   ((syn_mode == 3) ? 1'($urandom_range(0, 1)) : 1'b0);

        for (int i = 0; i < fill_len; i++)
        begin
            it.option_byte = seg_bytes[i];
            it.first_byte  = (i == 0) && (noise != 4);
            it.area_length = (i == odd_idx) ? 6'($urandom_range(1, 63)) : 6'(shown_area);
            it.syn_flag    = syn;
            it.past_syn    = past;
            if ($urandom_range(0, 9) == 0)
            begin
                it.syn_flag = 1'($urandom_range(0, 1));
                it.past_syn = 1'($urandom_range(0, 1));
            end
            send_request(it);
        end

        // stray bytes beyond the area end
        if (noise == 2)
            repeat ($urandom_range(1, 4))
            begin
                it.option_byte = 8'($urandom_range(0, 255));
                it.first_byte  = 1'b0;
                it.area_length = 6'($urandom_range(1, 63));
                it.syn_flag    = 1'($urandom_range(0, 1));
                it.past_syn    = 1'($urandom_range(0, 1));
                send_request(it);
            end
        segments++;
    endtask

    // One stretch of random segments under the given idle rates
    task automatic run_phase(input int quota, input int s_pct, input int r_pct,
                             input bit squeeze);
        int start;
        bit held;
        send_idle_pct = s_pct;
        recv_idle_pct = r_pct;
        start         = used_bytes;
        held          = 1'b0;
        while (used_bytes - start < quota)
        begin
            if (squeeze && !held && used_bytes - start >= quota / 3)
            begin
                hold_request = 1'b1;
                held         = 1'b1;
            end
            send_segment($urandom_range(0, 4) == 0);
        end
    endtask

    // Main sequence
    initial
    begin
        rst_n       = 1'b0;
        in_valid    = 1'b0;
        option_byte = '0;
        first_byte  = 1'b0;
        area_length = '0;
        syn_flag    = 1'b0;
        past_syn    = 1'b0;
        psel        = 1'b0;
        penable     = 1'b0;
        pwrite      = 1'b0;
        paddr       = '0;
        pwdata      = '0;
        tracker     = new();
        repeat (7) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        // Directed: MSS, window scale and both SACK options at their extremes on an initial SYN
        send_idle_pct = 30;
        recv_idle_pct = 30;
        seg_bytes = '{KIND_MSS, LEN_MSS, 8'hFF, 8'hFF, KIND_WSCALE, LEN_WSCALE, 8'hFF,
                      KIND_SACK_PERM, LEN_SACK_PERM, KIND_SACK, LEN_MIN, KIND_NOP};
        send_run(12, 1'b1, 1'b0);
        // timestamp on a later SYN
        seg_bytes = '{KIND_TS, LEN_TS, 8'hFF, 8'hFF, 8'hFF, 8'hFF,
                      8'h00, 8'h00, 8'h00, 8'h00};
        send_run(10, 1'b1, 1'b1);
        // kind in the last byte of a one-byte area
        seg_bytes = '{KIND_MSS};
        send_run(1, 1'b0, 1'b0);
        // length under two
        seg_bytes = '{8'h07, 8'h01};
        send_run(2, 1'b1, 1'b0);
        wait_quiet();

        write_sack_perm_en(1'b0);
        run_phase(BYTES_PER_PHASE, 17, 84, 1'b0);
        wait_quiet();

        write_sack_perm_en(1'b1);
        run_phase(BYTES_PER_PHASE, 84, 17, 1'b0);
        wait_quiet();

        write_sack_perm_en(1'b0);
        run_phase(BYTES_PER_PHASE, 0, 0, 1'b1);
        wait_quiet();

        $display("Run covered %0d segments, %0d option bytes parsed, %0d summaries checked",
                 segments, used_bytes, tracker.summaries_seen);
        $display("SACK permitted enable toggled both ways; one long receiver hold-off; %0d mismatches",
                 tracker.mismatches);
        if (tracker.mismatches == 0)
            $display("SUCCESS");
        else
            $display("FAILURE");
        $finish;
    end

endmodule
